// ===== hw/rtl/b32enc_pkg.sv =====
// Shared types and constants for the base32 custom-alphabet encoder.
// Holds the payload structs, register map and the two symbol alphabets.
// No dependencies.
package b32enc_pkg;

    localparam int unsigned DataWidth   = 8;
    localparam int unsigned SymWidth    = 5;
    localparam int unsigned CharWidth   = 7;
    localparam int unsigned AccWidth    = 12;
    localparam int unsigned HeldWidth   = 4;
    localparam int unsigned AlphaDepth  = 32;
    localparam int unsigned MaxSyms     = 3;
    localparam int unsigned PaddrWidth  = 3;

    // register word index (paddr[2])
    localparam logic RegAlphabetSelect = 1'b0;

    typedef struct packed {
        logic [DataWidth-1:0] data_byte;
        logic                 final_byte;
    } src_item_t;

    typedef struct packed {
        logic [CharWidth-1:0] symbol_char;
        logic                 final_symbol;
    } sym_item_t;

    localparam logic [7:0] ALPHA_FIRST [AlphaDepth] = '{
        "5", "6", "A", "F", "G", "H", "J", "B", "C", "D", "E", "K", "L", "V", "Z", "7",
        "M", "N", "P", "2", "Y", "T", "U", "8", "9", "3", "4", "Q", "R", "S", "W", "X"
    };

    localparam logic [7:0] ALPHA_SECOND [AlphaDepth] = '{
        "A", "D", "5", "H", "J", "K", "6", "E", "U", "V", "W", "F", "G", "L", "M", "N",
        "P", "2", "B", "C", "3", "4", "Q", "R", "S", "T", "X", "Y", "Z", "7", "8", "9"
    };

    function automatic logic [CharWidth-1:0] map_symbol(
        input logic                sel,
        input logic [SymWidth-1:0] idx
    );
        logic [7:0] c;
        begin
            c = sel ? ALPHA_SECOND[idx] : ALPHA_FIRST[idx];
            return c[CharWidth-1:0];
        end
    endfunction

endpackage

// ===== hw/rtl/base32_custom_alphabet_encoder_core.sv =====
// Base32 encoder core with two selectable fixed alphabets.
// Uses b32enc_pkg for payload structs, register map and alphabet tables.
// Single module: bit accumulator, symbol buffer, output register, APB register.

// Each accepted byte is merged into a 12-bit accumulator (acc = acc << 8 | byte)
// and split into one or two full 5-bit symbols, plus a zero-padded symbol on the
// byte marked final when bits remain; a message of n bytes gives ceil(8n/5)
// symbols, the last one flagged with final_symbol. Symbols leave one per cycle,
// while sym_ready allows, through a registered output; each byte yields 1 to 3
// symbols. A new byte is taken in the same cycle the last buffered symbol moves
// out. alphabet_select sits at byte address 0; the user must write it only while
// the encoder is idle, as the block itself does not enforce this.
module base32_custom_alphabet_encoder_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // byte input
    input  logic                                src_valid,
    output logic                                src_ready,
    input  b32enc_pkg::src_item_t               src_data,
    // symbol output
    output logic                                sym_valid,
    input  logic                                sym_ready,
    output b32enc_pkg::sym_item_t               sym_data,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [b32enc_pkg::PaddrWidth-1:0]   paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int unsigned SW = b32enc_pkg::SymWidth;
    localparam int unsigned AW = b32enc_pkg::AccWidth;
    localparam int unsigned HW = b32enc_pkg::HeldWidth;

    // config register
    logic alpha_sel_reg;
    logic cfg_wr;
    logic cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[2] == b32enc_pkg::RegAlphabetSelect);
    assign cfg_wr  = psel && penable && pwrite && cfg_hit;
    assign prdata  = cfg_hit ? {31'd0, alpha_sel_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_sel_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            alpha_sel_reg <= pwdata[0];
        end
    end

    // accumulator state; held count is 0..4 between bytes
    logic [AW-1:0]   acc_reg,  acc_next;
    logic [HW-2:0]   held_reg, held_next;

    // symbol buffer, entry 0 is next out
    logic [SW-1:0]   buf_sym_reg  [b32enc_pkg::MaxSyms];
    logic [SW-1:0]   buf_sym_next [b32enc_pkg::MaxSyms];
    logic [1:0]      buf_cnt_reg,  buf_cnt_next;
    logic            buf_last_reg, buf_last_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    b32enc_pkg::sym_item_t out_data_reg,  out_data_next;

    logic            src_fire;
    logic            pop;
    logic [AW-1:0]   merged;
    logic [HW-1:0]   held_sum;
    logic            two_full;
    logic [HW-1:0]   rem;
    logic            pad;

    assign pop       = (buf_cnt_reg != 2'd0) && (!out_valid_reg || sym_ready);
    assign src_ready = (buf_cnt_reg == 2'd0) || ((buf_cnt_reg == 2'd1) && pop);
    assign src_fire  = src_valid && src_ready;

    assign sym_valid = out_valid_reg;
    assign sym_data  = out_data_reg;

    always_comb
    begin
        merged   = {acc_reg[AW-9:0], src_data.data_byte};
        held_sum = {1'b0, held_reg} + HW'(8);
        two_full = (held_sum >= HW'(10));
        rem      = two_full ? (held_sum - HW'(10)) : (held_sum - HW'(5));
        pad      = src_data.final_byte && (rem != '0);

        acc_next      = acc_reg;
        held_next     = held_reg;
        buf_sym_next  = buf_sym_reg;
        buf_cnt_next  = buf_cnt_reg;
        buf_last_next = buf_last_reg;

        if (src_fire)
        begin
            buf_sym_next[0] = merged[SW-1:0];
            buf_sym_next[1] = merged[2*SW-1:SW];
            buf_sym_next[2] = {{(3*SW-AW){1'b0}}, merged[AW-1:2*SW]};
            buf_cnt_next    = 2'(two_full ? 2 : 1) + 2'(pad);
            buf_last_next   = src_data.final_byte;
            if (src_data.final_byte)
            begin
                acc_next  = '0;
                held_next = '0;
            end
            else
            begin
                acc_next  = two_full ? (merged >> (2*SW)) : (merged >> SW);
                held_next = rem[HW-2:0];
            end
        end
        else if (pop)
        begin
            buf_sym_next[0] = buf_sym_reg[1];
            buf_sym_next[1] = buf_sym_reg[2];
            buf_cnt_next    = buf_cnt_reg - 2'd1;
        end

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (pop)
        begin
            out_valid_next             = 1'b1;
            out_data_next.symbol_char  = b32enc_pkg::map_symbol(alpha_sel_reg, buf_sym_reg[0]);
            out_data_next.final_symbol = buf_last_reg && (buf_cnt_reg == 2'd1);
        end
        else if (sym_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            held_reg      <= '0;
            buf_cnt_reg   <= 2'd0;
            buf_last_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            held_reg      <= held_next;
            buf_cnt_reg   <= buf_cnt_next;
            buf_last_reg  <= buf_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_sym_reg  <= buf_sym_next;
        out_data_reg <= out_data_next;
    end

endmodule
